// ----- sv/abast_pkg.sv -----
// shared types and constants for the alpha-beta angle and speed tracker
package abast_pkg;

    localparam int ANGLE_EST_W = 25;
    localparam int FREQ_W      = 32;
    localparam int POS_W       = 16;
    localparam int SPEED_W     = 16;
    localparam int M_FIELDS_W  = ANGLE_EST_W + FREQ_W + POS_W + SPEED_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam int ALPHA_W     = 25;
    localparam int BETA_W      = 31;
    localparam int DT_W        = 25;
    localparam int SGAIN_W     = 12;
    localparam int CFG_DATA_W  = 31;
    localparam int CFG_ADDR_W  = 2;

    localparam int SPD_SHIFT   = 12;
    localparam int POS_MULT    = 9;

    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_GAIN   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BETA_OVER_DT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DT_STEP      = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_GAIN   = 2'd3;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 25'd1482505;
    localparam logic [BETA_W-1:0]  BETA_RESET  = 31'd4764889;
    localparam logic [DT_W-1:0]    DT_RESET    = 25'd838;
    localparam logic [SGAIN_W-1:0] SGAIN_RESET = 12'd220;

    typedef logic signed [FREQ_W:0]       mul_op_t;
    typedef logic signed [2*FREQ_W+1:0]   mul_prod_t;

endpackage

// ----- sv/alpha_beta_angle_speed_tracker_core.sv -----
// alpha-beta angle and speed tracker with one shared multiplier under a sequencer
//
//   channel  dir  handshake            payload (lowest bit up)
//   s_       in   s_tvalid/s_tready    angle_sample
//   m_       out  m_tvalid/m_tready    angle_estimate, frequency_estimate,
//                                      position_command, speed_command
//   cfg_     in   cfg_wr_en            cfg_addr selects register, cfg_wdata
//
// each request passes through the single 33x33 multiplier used four times
// and the add/wrap steps between them.
// s_tready is high only while the sequencer is idle.
// a finished result waits in the output register; the next request is
// taken while it waits and stalls only at its own final step.
// aresetn is synchronous, active low; it clears the estimates and loads the reset gains.
module alpha_beta_angle_speed_tracker_core #(
    parameter int ANGLE_BITS = 12,
    parameter int FRAC_BITS  = 24,
    parameter int S_TDATA_W  = ((ANGLE_BITS + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [S_TDATA_W-1:0]                s_tdata,   // angle_sample
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // angle_estimate, frequency_estimate, position_command, speed_command
    output logic [abast_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [abast_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [abast_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import abast_pkg::*;

    localparam logic signed [FREQ_W-1:0] Q_ONE     = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [FREQ_W-1:0] Q_ONE_NEG = -(32'sd1 <<< FRAC_BITS);
    localparam int SAMP_SHIFT = FRAC_BITS - ANGLE_BITS;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_MUL_PRED  = 4'd1;
    localparam logic [3:0] ST_ADD_PRED  = 4'd2;
    localparam logic [3:0] ST_WRAP_HI   = 4'd3;
    localparam logic [3:0] ST_WRAP_LO   = 4'd4;
    localparam logic [3:0] ST_ERR       = 4'd5;
    localparam logic [3:0] ST_EWRAP_HI  = 4'd6;
    localparam logic [3:0] ST_EWRAP_LO  = 4'd7;
    localparam logic [3:0] ST_MUL_ALPHA = 4'd8;
    localparam logic [3:0] ST_MUL_BETA  = 4'd9;
    localparam logic [3:0] ST_FREQ      = 4'd10;
    localparam logic [3:0] ST_MUL_SPD   = 4'd11;
    localparam logic [3:0] ST_SPD_WAIT  = 4'd12;
    localparam logic [3:0] ST_DONE      = 4'd13;

    logic [3:0]                state_reg, state_next;
    logic [ALPHA_W-1:0]        alpha_reg;
    logic [BETA_W-1:0]         beta_reg;
    logic [DT_W-1:0]           dt_reg;
    logic [SGAIN_W-1:0]        sgain_reg;
    logic signed [FREQ_W-1:0]  angle_state_reg;
    logic signed [FREQ_W-1:0]  freq_state_reg;
    logic signed [FREQ_W-1:0]  acc_reg;
    logic signed [FREQ_W-1:0]  err_reg;
    logic [ANGLE_BITS-1:0]     samp_reg;
    mul_prod_t                 prod_reg;
    logic                      m_valid_reg;
    logic [M_TDATA_W-1:0]      m_tdata_reg;

    mul_op_t                   mul_a, mul_b;
    logic signed [FREQ_W-1:0]  prod_q;
    logic signed [FREQ_W-1:0]  freq_shr;
    logic signed [FREQ_W-1:0]  spd_full;
    logic signed [SPEED_W-1:0] spd_sat;
    logic [FREQ_W-1:0]         samp_scaled;
    logic [ANGLE_BITS+3:0]     pos_full;
    logic [POS_W-1:0]          pos_cmd;
    logic                      out_free;
    logic                      s_fire;

    assign s_tready    = (state_reg == ST_IDLE);
    assign s_fire      = s_tvalid && s_tready;
    assign m_tvalid    = m_valid_reg;
    assign m_tdata     = m_tdata_reg;
    assign out_free    = !m_valid_reg || m_tready;

    assign prod_q      = prod_reg[FRAC_BITS +: FREQ_W];
    assign freq_shr    = freq_state_reg >>> SPD_SHIFT;
    assign spd_full    = prod_reg[SPD_SHIFT +: FREQ_W];
    assign samp_scaled = FREQ_W'(samp_reg) << SAMP_SHIFT;
    assign pos_full    = ({4'b0, samp_reg} << 3) + {4'b0, samp_reg};
    assign pos_cmd     = POS_W'(pos_full);

    always_comb begin
        if (spd_full > 32'sd32767) begin
            spd_sat = 16'sh7fff;
        end else if (spd_full < -32'sd32768) begin
            spd_sat = 16'sh8000;
        end else begin
            spd_sat = spd_full[SPEED_W-1:0];
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_PRED: begin
                mul_a = {freq_state_reg[FREQ_W-1], freq_state_reg};
                mul_b = $signed({8'b0, dt_reg});
            end
            ST_MUL_ALPHA: begin
                mul_a = $signed({8'b0, alpha_reg});
                mul_b = {err_reg[FREQ_W-1], err_reg};
            end
            ST_MUL_BETA: begin
                mul_a = {err_reg[FREQ_W-1], err_reg};
                mul_b = $signed({2'b0, beta_reg});
            end
            ST_MUL_SPD: begin
                mul_a = {freq_shr[FREQ_W-1], freq_shr};
                mul_b = $signed({21'b0, sgain_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_fire) state_next = ST_MUL_PRED;
            ST_MUL_PRED:  state_next = ST_ADD_PRED;
            ST_ADD_PRED:  state_next = ST_WRAP_HI;
            ST_WRAP_HI:   state_next = ST_WRAP_LO;
            ST_WRAP_LO:   state_next = ST_ERR;
            ST_ERR:       state_next = ST_EWRAP_HI;
            ST_EWRAP_HI:  state_next = ST_EWRAP_LO;
            ST_EWRAP_LO:  state_next = ST_MUL_ALPHA;
            ST_MUL_ALPHA: state_next = ST_MUL_BETA;
            ST_MUL_BETA:  state_next = ST_FREQ;
            ST_FREQ:      state_next = ST_MUL_SPD;
            ST_MUL_SPD:   state_next = ST_SPD_WAIT;
            ST_SPD_WAIT:  state_next = ST_DONE;
            ST_DONE:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            alpha_reg       <= ALPHA_RESET;
            beta_reg        <= BETA_RESET;
            dt_reg          <= DT_RESET;
            sgain_reg       <= SGAIN_RESET;
            angle_state_reg <= '0;
            freq_state_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_ALPHA_GAIN:   alpha_reg <= cfg_wdata[ALPHA_W-1:0];
                    REG_BETA_OVER_DT: beta_reg  <= cfg_wdata[BETA_W-1:0];
                    REG_DT_STEP:      dt_reg    <= cfg_wdata[DT_W-1:0];
                    REG_SPEED_GAIN:   sgain_reg <= cfg_wdata[SGAIN_W-1:0];
                    default: ;
                endcase
            end

            if (state_reg == ST_MUL_BETA) begin
                angle_state_reg <= acc_reg + prod_q;
            end
            if (state_reg == ST_FREQ) begin
                freq_state_reg <= freq_state_reg + prod_q;
            end

            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        // product holds until the next multiply step
        if (state_reg == ST_MUL_PRED || state_reg == ST_MUL_ALPHA ||
            state_reg == ST_MUL_BETA || state_reg == ST_MUL_SPD) begin
            prod_reg <= mul_a * mul_b;
        end
        if (s_fire) begin
            samp_reg <= s_tdata[ANGLE_BITS-1:0];
        end
        unique case (state_reg)
            ST_ADD_PRED: acc_reg <= angle_state_reg + prod_q;
            ST_WRAP_HI:  if (acc_reg > Q_ONE) acc_reg <= acc_reg - Q_ONE;
            ST_WRAP_LO:  if (acc_reg < 0) acc_reg <= acc_reg + Q_ONE;
            ST_ERR:      err_reg <= $signed(samp_scaled) - acc_reg;
            ST_EWRAP_HI: if (err_reg > Q_ONE) err_reg <= err_reg - Q_ONE;
            ST_EWRAP_LO: if (err_reg < Q_ONE_NEG) err_reg <= err_reg + Q_ONE;
            default: ;
        endcase
        if (state_reg == ST_DONE && out_free) begin
            m_tdata_reg <= {{(M_TDATA_W - M_FIELDS_W){1'b0}}, spd_sat, pos_cmd,
                            freq_state_reg, angle_state_reg[ANGLE_EST_W-1:0]};
        end
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking bench for the alpha-beta angle and speed tracker core
module tb_top;
    import abast_pkg::*;

    localparam int ABITS = 12;
    localparam int FRAC = 24;
    localparam int S_W = ((ABITS + 7) / 8) * 8;
    localparam int Q1 = 1 << FRAC;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic [POS_W-1:0] pos;
        logic signed [FREQ_W-1:0] freq;
        logic [ANGLE_EST_W-1:0] angle;
    } track_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic [ALPHA_W-1:0] g_alpha = ALPHA_RESET;
    logic [BETA_W-1:0] g_beta = BETA_RESET;
    logic [DT_W-1:0] g_dt = DT_RESET;
    logic [SGAIN_W-1:0] g_sgain = SGAIN_RESET;
    int trk_angle = 0;
    int trk_freq = 0;

    logic [ABITS-1:0] sample_q[$];
    track_res_t estimate_q[$];
    track_res_t got_res;
    track_res_t want_res;

    int unsigned n_queued = 0;
    int unsigned n_accepted = 0;
    int unsigned n_seen = 0;
    int unsigned n_cfg = 0;
    int unsigned bad_count = 0;
    int unsigned src_gap = 0;
    int unsigned sink_gap = 0;
    logic idle_en = 1'b1;
    logic sink_hold = 1'b0;

    alpha_beta_angle_speed_tracker_core dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic int qmul(input longint a, input longint b);
        int r;
        r = (a * b) >>> FRAC;
        return r;
    endfunction

    function automatic track_res_t track_step(input logic [ABITS-1:0] smp);
        longint dt_l, al_l, be_l, sg_l, f_l, spd;
        int pred, err, samp_q;
        track_res_t r;
        dt_l = g_dt;
        al_l = g_alpha;
        be_l = g_beta;
        sg_l = g_sgain;
        pred = trk_angle + qmul(trk_freq, dt_l);
        if (pred > Q1) pred = pred - Q1;
        if (pred < 0) pred = pred + Q1;
        samp_q = smp;
        samp_q = samp_q << (FRAC - ABITS);
        err = samp_q - pred;
        if (err > Q1) err = err - Q1;
        if (err < -Q1) err = err + Q1;
        trk_angle = pred + qmul(al_l, err);
        trk_freq = trk_freq + qmul(err, be_l);
        f_l = trk_freq;
        spd = ((f_l >>> SPD_SHIFT) * sg_l) >>> SPD_SHIFT;
        if (spd > 32767) spd = 32767;
        if (spd < -32768) spd = -32768;
        r.angle = trk_angle[ANGLE_EST_W-1:0];
        r.freq = trk_freq;
        r.pos = POS_W'(smp * POS_MULT);
        r.speed = spd[SPEED_W-1:0];
        return r;
    endfunction

    task automatic report_bad(input string what, input longint want, input longint got);
        bad_count++;
        if (bad_count <= 10) $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endtask

    // sample driver, predicts on each accepted request
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                estimate_q.push_back(track_step(s_tdata[ABITS-1:0]));
                n_accepted <= n_accepted + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap != 0) begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (sample_q.size() != 0) begin
                    s_tdata <= {{(S_W - ABITS){1'b0}}, sample_q.pop_front()};
                    s_tvalid <= 1'b1;
                    if (idle_en && $urandom_range(0, 3) == 0) src_gap <= $urandom_range(1, 5);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (sink_hold) begin
            m_tready <= 1'b0;
        end else if (sink_gap != 0) begin
            m_tready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else if (idle_en && $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            sink_gap <= $urandom_range(0, 4);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            n_seen <= n_seen + 1;
            got_res = m_tdata[M_FIELDS_W-1:0];
            if (estimate_q.size() == 0) begin
                bad_count++;
                if (bad_count <= 10) $display("result with no request pending: %h", got_res);
            end else begin
                want_res = estimate_q.pop_front();
                if (got_res.angle !== want_res.angle)
                    report_bad("angle_estimate", want_res.angle, got_res.angle);
                if (got_res.freq !== want_res.freq)
                    report_bad("frequency_estimate", want_res.freq, got_res.freq);
                if (got_res.pos !== want_res.pos)
                    report_bad("position_command", want_res.pos, got_res.pos);
                if (got_res.speed !== want_res.speed)
                    report_bad("speed_command", want_res.speed, got_res.speed);
            end
        end
    end

    // long output stall so the core backs up into its input
    initial begin
        wait (n_accepted >= 120);
        @(posedge aclk);
        sink_hold <= 1'b1;
        repeat (300) @(posedge aclk);
        sink_hold <= 1'b0;
    end

    initial begin
        #10ms;
        $display("alpha_beta_angle_speed_tracker_core regression: fail");
        $finish;
    end

    task automatic push_sample(input logic [ABITS-1:0] smp);
        sample_q.push_back(smp);
        n_queued++;
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_ALPHA_GAIN: g_alpha = val[ALPHA_W-1:0];
            REG_BETA_OVER_DT: g_beta = val[BETA_W-1:0];
            REG_DT_STEP: g_dt = val[DT_W-1:0];
            REG_SPEED_GAIN: g_sgain = val[SGAIN_W-1:0];
            default: ;
        endcase
        n_cfg++;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_gains(input int unsigned al, input int unsigned be,
                               input int unsigned dt, input int unsigned sg);
        write_reg(REG_ALPHA_GAIN, CFG_DATA_W'(al));
        write_reg(REG_BETA_OVER_DT, CFG_DATA_W'(be));
        write_reg(REG_DT_STEP, CFG_DATA_W'(dt));
        write_reg(REG_SPEED_GAIN, CFG_DATA_W'(sg));
    endtask

    task automatic settle();
        while (n_accepted != n_queued || n_seen != n_accepted) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // rotating angle runs with jitter, mixed with unrelated samples
    task automatic queue_track(input int unsigned count);
        int unsigned i, run;
        int step, noise;
        logic [ABITS-1:0] pos;
        run = 0;
        step = 0;
        pos = ABITS'($urandom());
        for (i = 0; i < count; i++) begin
            if (run == 0) begin
                run = $urandom_range(5, 60);
                step = int'($urandom_range(0, 400)) - 200;
                if ($urandom_range(0, 9) == 0) step = $urandom_range(0, 4095);
            end
            run--;
            if ($urandom_range(0, 9) < 8) begin
                noise = int'($urandom_range(0, 6)) - 3;
                pos = pos + step[ABITS-1:0] + noise[ABITS-1:0];
                push_sample(pos);
            end else begin
                push_sample(ABITS'($urandom()));
            end
        end
    endtask

    initial begin
        int unsigned k;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset gains, field extremes and bit patterns
        push_sample(12'd0);
        push_sample(12'd4095);
        push_sample(12'd0);
        push_sample(12'd2048);
        push_sample(12'd1);
        push_sample(12'd4094);
        push_sample(12'hAAA);
        push_sample(12'h555);
        push_sample(12'h800);
        push_sample(12'h7FF);
        push_sample(12'd100);
        push_sample(12'd200);
        push_sample(12'd300);
        push_sample(12'd400);
        settle();

        // largest gains drive wrap and speed saturation
        write_gains(Q1, 32'h7FFF_FFFF, Q1, 4095);
        push_sample(12'd0);
        push_sample(12'd4095);
        push_sample(12'd2048);
        push_sample(12'd0);
        push_sample(12'd4095);
        push_sample(12'd1024);
        settle();

        // bits above the register widths are dropped
        write_reg(REG_ALPHA_GAIN, '1);
        write_reg(REG_DT_STEP, '1);
        write_reg(REG_SPEED_GAIN, '1);
        push_sample(12'd3000);
        push_sample(12'd17);
        settle();

        write_gains(0, 0, 0, 0);
        push_sample(12'd4095);
        push_sample(12'd2047);
        settle();

        for (k = 0; k < 5; k++) begin
            case (k)
                0: write_gains(32'(ALPHA_RESET), 32'(BETA_RESET), 32'(DT_RESET),
                               32'(SGAIN_RESET));
                1: write_gains($urandom_range(0, Q1), $urandom() & 32'h7FFF_FFFF,
                               $urandom_range(0, Q1), $urandom_range(0, 4095));
                2: write_gains(Q1, 32'h7FFF_FFFF, Q1, 4095);
                3: write_gains($urandom_range(0, 1 << 21), $urandom_range(0, 1 << 24),
                               $urandom_range(0, 4096), $urandom_range(0, 511));
                default: write_gains(32'(ALPHA_RESET), 32'(BETA_RESET), 32'(DT_RESET),
                                     32'(SGAIN_RESET));
            endcase
            idle_en <= (k != 2 && k != 4);
            queue_track(300);
            settle();
        end

        repeat (30) @(posedge aclk);
        if (estimate_q.size() != 0) begin
            bad_count += estimate_q.size();
            $display("%0d expected results never arrived", estimate_q.size());
        end
        $display("checked %0d tracker results across %0d register writes", n_seen, n_cfg);
        $display("covered gain extremes, oversized writes, random gains and a long output stall");
        if (bad_count == 0) begin
            $display("alpha_beta_angle_speed_tracker_core regression: pass");
        end else begin
            $display("alpha_beta_angle_speed_tracker_core regression: fail");
        end
        $finish;
    end

endmodule
